// ----- design/bfid_pkg.sv -----
// Shared constants for the bidirectional flow id table.
`timescale 1ns / 1ps

package bfid_pkg;

  localparam int FLOW_CAPACITY = 1024;

  // Canonical key: low address, high address, protocol, low-side port, high-side port.
  localparam int KEY_W = 104;
  localparam int FLOW_NUM_W = 11;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [63:0] HASH_K_ADDR = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_K_REST = 64'hC2B2AE3D27D4EB4F;

endpackage

// ----- design/bfid_in_if.sv -----
// Input channel carrying the parsed header fields of one packet.
`timescale 1ns / 1ps

interface bfid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  proto;
  logic [15:0] src_port_raw;
  logic [15:0] dst_port_raw;
  logic [17:0] pkt_len;
  logic [31:0] stamp_sec;
  logic [19:0] stamp_usec;

  modport source (
    output valid, src_addr, dst_addr, proto, src_port_raw, dst_port_raw,
           pkt_len, stamp_sec, stamp_usec,
    input  ready
  );
  modport sink (
    input  valid, src_addr, dst_addr, proto, src_port_raw, dst_port_raw,
           pkt_len, stamp_sec, stamp_usec,
    output ready
  );
endinterface

// ----- design/bfid_out_if.sv -----
// Output channel carrying the flow lookup result of one packet.
`timescale 1ns / 1ps

interface bfid_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] flow_number;
  logic [31:0] low_addr;
  logic [31:0] high_addr;
  logic [7:0]  proto_out;
  logic [15:0] low_side_port;
  logic [15:0] high_side_port;
  logic        reverse_dir;
  logic        new_flow;
  logic        table_full;
  logic [17:0] len_out;
  logic [31:0] sec_out;
  logic [19:0] usec_out;

  modport source (
    output valid, flow_number, low_addr, high_addr, proto_out, low_side_port,
           high_side_port, reverse_dir, new_flow, table_full, len_out, sec_out,
           usec_out,
    input  ready
  );
  modport sink (
    input  valid, flow_number, low_addr, high_addr, proto_out, low_side_port,
           high_side_port, reverse_dir, new_flow, table_full, len_out, sec_out,
           usec_out,
    output ready
  );
endinterface

// ----- design/bfid_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bfid_hash.sv -----
// Iterative slot hash: one shared 32x32 multiplier for mixing, folding and the remainder.
`timescale 1ns / 1ps

module bfid_hash #(
  parameter int FLOW_CAPACITY = bfid_pkg::FLOW_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bfid_pkg::KEY_W-1:0]       key,
  output logic                             done,
  output logic [$clog2(FLOW_CAPACITY)-1:0] slot
);

  localparam int IW = $clog2(FLOW_CAPACITY);
  // 2^32 mod capacity folds the upper word down; the reciprocal gives the quotient.
  localparam logic [31:0] CAP32  = 32'(FLOW_CAPACITY);
  localparam logic [31:0] FOLD_K = 32'((64'd1 << 32) % 64'(FLOW_CAPACITY));
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / 64'(FLOW_CAPACITY));

  typedef enum logic [7:0] {
    HS_IDLE = 8'b00000001,
    HS_MUL  = 8'b00000010,
    HS_FOLD = 8'b00000100,
    HS_ADD  = 8'b00001000,
    HS_QUOT = 8'b00010000,
    HS_BACK = 8'b00100000,
    HS_SUB  = 8'b01000000,
    HS_FIX  = 8'b10000000
  } hs_state_t;

  hs_state_t   state;
  logic [2:0]  step;
  logic [63:0] addrs;
  logic [63:0] rest;
  logic [63:0] acc;
  logic [63:0] hreg;
  logic [63:0] prod;
  logic [31:0] rem;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] acc_hi;
  logic [63:0] h_mix;

  // Low 64 bits of a 64x64 product: a0*b0 + ((a0*b1 + a1*b0) << 32).
  // Folding multiplies the upper word by 2^32 mod capacity, and the remainder
  // takes an estimated quotient from the reciprocal, then multiplies it back.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      HS_MUL: begin
        case (step)
          3'd0: begin mul_a = addrs[31:0];  mul_b = bfid_pkg::HASH_K_ADDR[31:0];  end
          3'd1: begin mul_a = addrs[31:0];  mul_b = bfid_pkg::HASH_K_ADDR[63:32]; end
          3'd2: begin mul_a = addrs[63:32]; mul_b = bfid_pkg::HASH_K_ADDR[31:0];  end
          3'd3: begin mul_a = rest[31:0];   mul_b = bfid_pkg::HASH_K_REST[31:0];  end
          3'd4: begin mul_a = rest[31:0];   mul_b = bfid_pkg::HASH_K_REST[63:32]; end
          3'd5: begin mul_a = rest[63:32];  mul_b = bfid_pkg::HASH_K_REST[31:0];  end
          default: ;
        endcase
      end
      HS_FOLD: begin mul_a = hreg[63:32]; mul_b = FOLD_K; end
      HS_QUOT: begin mul_a = hreg[31:0];  mul_b = RECIP;  end
      HS_BACK: begin mul_a = prod[63:32]; mul_b = CAP32;  end
      default: ;
    endcase
  end

  assign acc_hi = acc + {prod[31:0], 32'd0};
  assign h_mix  = hreg ^ acc_hi;

  always_ff @(posedge clk) begin
    done <= !rst && (state == HS_FIX);
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
    if (rst) begin
      state <= HS_IDLE;
    end else begin
      case (state)
        HS_IDLE: begin
          if (start) begin
            addrs <= key[103:40];
            rest  <= {24'd0, key[39:0]};
            step  <= 3'd0;
            state <= HS_MUL;
          end
        end
        HS_MUL: begin
          step <= step + 3'd1;
          case (step)
            3'd1: acc <= prod;
            3'd2: acc <= acc_hi;
            3'd3: hreg <= acc_hi ^ (acc_hi >> 29);
            3'd4: acc <= prod;
            3'd5: acc <= acc_hi;
            3'd6: begin
              hreg  <= h_mix ^ (h_mix >> 32);
              state <= HS_FOLD;
            end
            default: ;
          endcase
        end
        HS_FOLD: begin
          // At most four rounds bring a 64-bit hash below 2^32.
          if (hreg[63:32] == 32'd0) begin
            state <= HS_QUOT;
          end else begin
            state <= HS_ADD;
          end
        end
        HS_ADD: begin
          hreg  <= prod + {32'd0, hreg[31:0]};
          state <= HS_FOLD;
        end
        HS_QUOT: begin
          state <= HS_BACK;
        end
        HS_BACK: begin
          state <= HS_SUB;
        end
        HS_SUB: begin
          // The quotient estimate is low by at most one, so this is below twice the capacity.
          rem   <= hreg[31:0] - prod[31:0];
          state <= HS_FIX;
        end
        HS_FIX: begin
          rem   <= (rem >= CAP32) ? rem - CAP32 : rem;
          state <= HS_IDLE;
        end
        default: state <= HS_IDLE;
      endcase
    end
  end

  assign slot = rem[IW-1:0];

endmodule

// ----- design/bidirectional_flow_id_table.sv -----
// Top level of the bidirectional five-tuple flow id table.
//
//   Channel  Role   Handshake      Content
//   in_ch    sink   valid/ready    parsed IPv4 header fields, length, timestamp
//   out_ch   source valid/ready    flow id, canonical tuple, direction, flags
//
// After reset a clearing pass writes every table entry, and no transaction is
// taken until it ends.
// Each accepted packet passes in order through the mixing and then F folding
// rounds of the hash (F at most four) on the shared 32x32 multiplier, the
// reciprocal remainder, the handover of the slot, a read and a check of each
// probed slot on the table RAM's registered read port, and the load of the
// output register, which waits while a previous result has not been taken,
// before the block is idle again.
// The block holds one packet at a time; the output register lets the next
// packet enter while the previous result waits to be taken.
// Reset is synchronous and active high.
`timescale 1ns / 1ps

module bidirectional_flow_id_table #(
  parameter int FLOW_CAPACITY = bfid_pkg::FLOW_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  bfid_in_if.sink    in_ch,
  bfid_out_if.source out_ch
);

  localparam int IW = $clog2(FLOW_CAPACITY);
  localparam int NW = $clog2(FLOW_CAPACITY + 1);
  localparam int EW = 1 + bfid_pkg::KEY_W + IW;
  localparam logic [NW-1:0] CAP_N  = NW'(FLOW_CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(FLOW_CAPACITY - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_RD    = 6'b001000,
    ST_CHK   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Captured packet.
  logic [bfid_pkg::KEY_W-1:0] key;
  logic        rev;
  logic [17:0] len;
  logic [31:0] sec;
  logic [19:0] usec;

  // Lookup control.
  logic [IW-1:0] clr_idx;
  logic [IW-1:0] idx;
  logic [IW-1:0] n;
  logic [NW-1:0] next_id;
  logic [NW-1:0] fid_res;
  logic          new_res;
  logic          full_res;

  logic          out_valid;

  // Canonical ordering of the incoming tuple. Equal addresses count as swapped.
  logic        l4;
  logic [15:0] sport;
  logic [15:0] dport;
  logic        swap;
  logic [bfid_pkg::KEY_W-1:0] key_in;

  assign l4    = (in_ch.proto == bfid_pkg::PROTO_TCP) || (in_ch.proto == bfid_pkg::PROTO_UDP);
  assign sport = l4 ? in_ch.src_port_raw : 16'd0;
  assign dport = l4 ? in_ch.dst_port_raw : 16'd0;
  assign swap  = !(in_ch.src_addr < in_ch.dst_addr);
  assign key_in = swap ? {in_ch.dst_addr, in_ch.src_addr, in_ch.proto, dport, sport}
                       : {in_ch.src_addr, in_ch.dst_addr, in_ch.proto, sport, dport};

  assign in_ch.ready = (state == ST_IDLE);

  // Hash unit.
  logic          hash_done;
  logic [IW-1:0] hash_slot;

  bfid_hash #(.FLOW_CAPACITY(FLOW_CAPACITY)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (in_ch.valid && in_ch.ready),
    .key   (key_in),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  // Table RAM: each entry holds a valid bit, the canonical key and the flow id.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] rd_entry;
  logic          rd_valid;
  logic [bfid_pkg::KEY_W-1:0] rd_key;
  logic [IW-1:0] rd_fid;
  logic          ins;

  assign rd_valid = rd_entry[EW-1];
  assign rd_key   = rd_entry[EW-2 -: bfid_pkg::KEY_W];
  assign rd_fid   = rd_entry[IW-1:0];

  // A free slot takes the key only while flow ids remain.
  assign ins = (state == ST_CHK) && !rd_valid && (next_id < CAP_N);

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = ins;
      ram_waddr = idx;
      ram_wdata = {1'b1, key, next_id[IW-1:0]};
    end
  end

  bfid_ram #(.WIDTH(EW), .DEPTH(FLOW_CAPACITY)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      next_id   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == LAST_I) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            key   <= key_in;
            rev   <= swap;
            len   <= in_ch.pkt_len;
            sec   <= in_ch.stamp_sec;
            usec  <= in_ch.stamp_usec;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            idx   <= hash_slot;
            n     <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (!rd_valid) begin
            state <= ST_DONE;
            if (next_id < CAP_N) begin
              fid_res  <= next_id;
              new_res  <= 1'b1;
              full_res <= 1'b0;
              next_id  <= next_id + NW'(1);
            end else begin
              fid_res  <= CAP_N;
              new_res  <= 1'b0;
              full_res <= 1'b1;
            end
          end else if (rd_key == key) begin
            fid_res  <= NW'(rd_fid);
            new_res  <= 1'b0;
            full_res <= 1'b0;
            state    <= ST_DONE;
          end else if (n == LAST_I) begin
            // Every slot probed without a match or a free entry.
            fid_res  <= CAP_N;
            new_res  <= 1'b0;
            full_res <= 1'b1;
            state    <= ST_DONE;
          end else begin
            n     <= n + IW'(1);
            idx   <= (idx == LAST_I) ? '0 : idx + IW'(1);
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register, loaded when the result leaves ST_DONE.
  logic [10:0] flow_number;
  logic [bfid_pkg::KEY_W-1:0] key_o;
  logic        rev_o;
  logic        new_o;
  logic        full_o;
  logic [17:0] len_o;
  logic [31:0] sec_o;
  logic [19:0] usec_o;

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
      flow_number <= 11'(fid_res);
      key_o       <= key;
      rev_o       <= rev;
      new_o       <= new_res;
      full_o      <= full_res;
      len_o       <= len;
      sec_o       <= sec;
      usec_o      <= usec;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.flow_number    = flow_number;
  assign out_ch.low_addr       = key_o[103:72];
  assign out_ch.high_addr      = key_o[71:40];
  assign out_ch.proto_out      = key_o[39:32];
  assign out_ch.low_side_port  = key_o[31:16];
  assign out_ch.high_side_port = key_o[15:0];
  assign out_ch.reverse_dir    = rev_o;
  assign out_ch.new_flow       = new_o;
  assign out_ch.table_full     = full_o;
  assign out_ch.len_out        = len_o;
  assign out_ch.sec_out        = sec_o;
  assign out_ch.usec_out       = usec_o;

  // The id counter never passes the capacity.
  a_next_id_bound: assert property (@(posedge clk) disable iff (rst)
    next_id <= CAP_N) else $error("flow id counter above capacity");

  // A write during lookup only ever lands on a free slot.
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> !rd_valid) else $error("insert over a live entry");

  // A result is never both new and a table-full miss.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(new_o && full_o)) else $error("new_flow and table_full together");

  // Each insert advances the id counter by exactly one.
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    ins |=> (next_id == $past(next_id) + NW'(1))) else $error("id counter did not advance");

endmodule

// ----- sim/bidirectional_flow_id_table_tb.sv -----
// Self-checking testbench for the bidirectional flow id table.
`timescale 1ns / 1ps

module bidirectional_flow_id_table_tb;

  // One packet header as the sender presents it.
  typedef struct {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [17:0] pkt_len;
    logic [31:0] sec;
    logic [19:0] usec;
  } header_t;

  // One flow lookup result, laid out like the output channel.
  typedef struct packed {
    logic [10:0] flow_number;
    logic [31:0] low_addr;
    logic [31:0] high_addr;
    logic [7:0]  proto_out;
    logic [15:0] low_side_port;
    logic [15:0] high_side_port;
    logic        reverse_dir;
    logic        new_flow;
    logic        table_full;
    logic [17:0] len_out;
    logic [31:0] sec_out;
    logic [19:0] usec_out;
  } lookup_t;

  // The scoreboard keeps its own flow table. Every accepted header is turned
  // into the lookup result that the block must give for it, and results
  // leave in the order their headers came in.
  class flow_scoreboard;
    logic [bfid_pkg::KEY_W-1:0] slot_key [bfid_pkg::FLOW_CAPACITY];
    bit               slot_used [bfid_pkg::FLOW_CAPACITY];
    int unsigned      slot_id [bfid_pkg::FLOW_CAPACITY];
    int unsigned      flows_made;
    int unsigned      full_hits;
    int unsigned      mismatches;
    lookup_t          awaited [$];

    function void clear();
      foreach (slot_used[i]) slot_used[i] = 0;
      flows_made = 0;
      full_hits = 0;
      mismatches = 0;
      awaited.delete();
    endfunction

    function int unsigned home_slot(logic [63:0] addrs, logic [63:0] rest);
      logic [63:0] h;
      h = addrs * bfid_pkg::HASH_K_ADDR;
      h ^= h >> 29;
      h ^= rest * bfid_pkg::HASH_K_REST;
      h ^= h >> 32;
      return int'(h % 64'(bfid_pkg::FLOW_CAPACITY));
    endfunction

    function void note_header(header_t hd);
      lookup_t          r;
      logic [15:0]      sp, dp;
      logic [63:0]      addrs, rest;
      logic [bfid_pkg::KEY_W-1:0] key;
      int unsigned      idx, n, fid;
      bit               found;
      found = 0;
      fid = 0;
      sp = hd.src_port;
      dp = hd.dst_port;
      if (hd.proto != bfid_pkg::PROTO_TCP && hd.proto != bfid_pkg::PROTO_UDP) begin
        sp = '0;
        dp = '0;
      end
      // Equal addresses count as swapped.
      r.reverse_dir = !(hd.src_addr < hd.dst_addr);
      if (r.reverse_dir) begin
        r.low_addr = hd.dst_addr;  r.high_addr = hd.src_addr;
        r.low_side_port = dp;      r.high_side_port = sp;
      end else begin
        r.low_addr = hd.src_addr;  r.high_addr = hd.dst_addr;
        r.low_side_port = sp;      r.high_side_port = dp;
      end
      addrs = {r.low_addr, r.high_addr};
      rest = {24'd0, hd.proto, r.low_side_port, r.high_side_port};
      key = {addrs, rest[39:0]};
      idx = home_slot(addrs, rest);
      for (n = 0; n < bfid_pkg::FLOW_CAPACITY; n++) begin
        if (!slot_used[idx]) break;
        if (slot_key[idx] == key) begin
          found = 1;
          fid = slot_id[idx];
          break;
        end
        idx = (idx + 1) % bfid_pkg::FLOW_CAPACITY;
      end
      r.new_flow = 0;
      r.table_full = 0;
      if (!found) begin
        if (flows_made < bfid_pkg::FLOW_CAPACITY && n < bfid_pkg::FLOW_CAPACITY &&
            !slot_used[idx]) begin
          slot_key[idx] = key;
          slot_used[idx] = 1;
          slot_id[idx] = flows_made;
          fid = flows_made;
          flows_made++;
          r.new_flow = 1;
        end else begin
          fid = bfid_pkg::FLOW_CAPACITY;
          r.table_full = 1;
          full_hits++;
        end
      end
      r.flow_number = fid[bfid_pkg::FLOW_NUM_W-1:0];
      r.proto_out = hd.proto;
      r.len_out = hd.pkt_len;
      r.sec_out = hd.sec;
      r.usec_out = hd.usec;
      awaited.push_back(r);
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst;
  bit   calm = 0;  // when set, neither side inserts idle cycles
  int   quiet_cycles = 0;

  bfid_in_if  in_ch ();
  bfid_out_if out_ch ();
  flow_scoreboard flows = new();
  header_t        known_flows [$];

  bidirectional_flow_id_table DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function bit take_break();
    return !calm && ($urandom_range(0, 99) < 31);
  endfunction

  // The sink stalls at random; all changes happen at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= rst ? 1'b0 : !take_break();
  end

  // Results are sampled at the rising edge. The watchdog counts edges at
  // which no transaction moves on either channel.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      flows.check_lookup({out_ch.flow_number, out_ch.low_addr, out_ch.high_addr,
                          out_ch.proto_out, out_ch.low_side_port, out_ch.high_side_port,
                          out_ch.reverse_dir, out_ch.new_flow, out_ch.table_full,
                          out_ch.len_out, out_ch.sec_out, out_ch.usec_out});
    end
    if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bidirectional_flow_id_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one header and returns at the rising edge of its transaction.
  // Valid is only lowered during idle cycles, never between back-to-back items.
  task automatic send_header(input header_t hd);
    while (take_break()) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.src_addr <= hd.src_addr;
    in_ch.dst_addr <= hd.dst_addr;
    in_ch.proto <= hd.proto;
    in_ch.src_port_raw <= hd.src_port;
    in_ch.dst_port_raw <= hd.dst_port;
    in_ch.pkt_len <= hd.pkt_len;
    in_ch.stamp_sec <= hd.sec;
    in_ch.stamp_usec <= hd.usec;
    do @(posedge clk); while (!in_ch.ready);
    flows.note_header(hd);
  endtask

  task automatic send_tuple(input logic [31:0] s, input logic [31:0] d,
                            input logic [7:0] p, input logic [15:0] sp,
                            input logic [15:0] dp);
    header_t hd;
    hd.src_addr = s;
    hd.dst_addr = d;
    hd.proto = p;
    hd.src_port = sp;
    hd.dst_port = dp;
    hd.pkt_len = 18'($urandom_range(0, 262143));
    hd.sec = $urandom();
    // Mostly legal microseconds, now and then any 20-bit value.
    hd.usec = ($urandom_range(0, 9) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 999999));
    known_flows.push_back(hd);
    send_header(hd);
  endtask

  // A fresh tuple with a protocol mix that favors the ones carrying ports.
  task automatic send_random_tuple();
    logic [31:0] s, d;
    logic [7:0]  p;
    s = $urandom();
    d = ($urandom_range(0, 19) == 0) ? s : $urandom();
    case ($urandom_range(0, 3))
      0, 1: p = bfid_pkg::PROTO_TCP;
      2: p = bfid_pkg::PROTO_UDP;
      default: p = 8'($urandom());
    endcase
    send_tuple(s, d, p, 16'($urandom()), 16'($urandom()));
  endtask

  // Sends a packet of a flow already seen, in either direction.
  task automatic send_repeat();
    header_t hd;
    hd = known_flows[$urandom_range(0, known_flows.size() - 1)];
    if ($urandom_range(0, 1)) begin
      {hd.src_addr, hd.dst_addr} = {hd.dst_addr, hd.src_addr};
      {hd.src_port, hd.dst_port} = {hd.dst_port, hd.src_port};
    end
    hd.pkt_len = 18'($urandom());
    hd.sec = $urandom();
    hd.usec = 20'($urandom_range(0, 999999));
    send_header(hd);
  endtask

  initial begin
    header_t hd;
    int      n;
    flows.clear();
    in_ch.valid = 0;
    in_ch.src_addr = '0;
    in_ch.dst_addr = '0;
    in_ch.proto = '0;
    in_ch.src_port_raw = '0;
    in_ch.dst_port_raw = '0;
    in_ch.pkt_len = '0;
    in_ch.stamp_sec = '0;
    in_ch.stamp_usec = '0;
    rst = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: address and port extremes, both protocols that carry
    // ports, others whose ports must be dropped, equal addresses, and the
    // same flow seen from both ends.
    send_tuple(32'h0, 32'hFFFF_FFFF, bfid_pkg::PROTO_TCP, 16'h0, 16'hFFFF);
    send_tuple(32'hFFFF_FFFF, 32'h0, bfid_pkg::PROTO_TCP, 16'hFFFF, 16'h0);
    send_tuple(32'h0A00_0001, 32'h0A00_0001, bfid_pkg::PROTO_UDP, 16'd53, 16'd4000);
    send_tuple(32'h0A00_0001, 32'h0A00_0001, bfid_pkg::PROTO_UDP, 16'd4000, 16'd53);
    send_tuple(32'hC0A8_0001, 32'h0808_0808, bfid_pkg::PROTO_UDP, 16'h1234, 16'h0035);
    send_tuple(32'h0808_0808, 32'hC0A8_0001, bfid_pkg::PROTO_UDP, 16'h0035, 16'h1234);
    send_tuple(32'h0102_0304, 32'h0506_0708, 8'd0, 16'hFFFF, 16'hAAAA);
    send_tuple(32'h0102_0304, 32'h0506_0708, 8'd255, 16'h5555, 16'hFFFF);
    send_tuple(32'h0506_0708, 32'h0102_0304, 8'd1, 16'h0001, 16'h0002);
    send_tuple(32'h0, 32'h0, 8'd0, 16'h0, 16'h0);
    send_tuple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 16'hFFFF);
    hd = known_flows[0];
    hd.pkt_len = 18'h3FFFF;
    hd.sec = 32'hFFFF_FFFF;
    hd.usec = 20'hFFFFF;
    send_header(hd);
    hd.pkt_len = '0;
    hd.sec = '0;
    hd.usec = 20'd999999;
    send_header(hd);

    // Hold the sender until the block has drained completely.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (flows.awaited.size() != 0) @(posedge clk);

    // Random part: mostly new flows with repeats mixed in, until the table
    // has filled and at least 30 packets have met it full, or 3000 have gone.
    n = 0;
    while ((flows.flows_made < bfid_pkg::FLOW_CAPACITY || flows.full_hits < 30) &&
           n < 3000) begin
      calm = (n >= 200 && n < 400);
      if ($urandom_range(0, 99) < 85) send_random_tuple();
      else send_repeat();
      n++;
    end
    calm = 0;
    // Known flows must still be found in a full table.
    repeat (20) send_repeat();
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (flows.awaited.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (flows.mismatches == 0 && flows.awaited.size() == 0) begin
      $display("PASS bidirectional_flow_id_table");
    end else begin
      $display("FAIL bidirectional_flow_id_table");
    end
    $finish;
  end

endmodule

// ----- bidirectional_flow_id_table.f -----
design/bfid_pkg.sv
design/bfid_in_if.sv
design/bfid_out_if.sv
design/bfid_ram.sv
design/bfid_hash.sv
design/bidirectional_flow_id_table.sv
sim/bidirectional_flow_id_table_tb.sv
